@@ hdl/ifd_pkg.sv @@
package ifd_pkg;

    localparam int unsigned HDR_BYTES   = 14;
    localparam int unsigned MAGIC_BYTES = 6;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd8388608;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_EMPTY     = 3'd1,
        KIND_BAD_MAGIC = 3'd2,
        KIND_TOO_LONG  = 3'd3,
        KIND_REJECTED  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [31:0] frame_type;
        logic        last_of_frame;
    } result_t;

    // Expected magic byte at a header position ("i3-ipc").
    function automatic logic [7:0] magic_byte(input logic [2:0] pos);
        logic [7:0] val;
        case (pos)
            3'd0:    val = 8'h69;
            3'd1:    val = 8'h33;
            3'd2:    val = 8'h2D;
            3'd3:    val = 8'h69;
            3'd4:    val = 8'h70;
            3'd5:    val = 8'h63;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

@@ hdl/ipc_frame_deframer.sv @@
// Length-prefixed frame deframer.
// Input channel: in_valid / in_ready with byte_in, one stream byte per request.
// Output channel: out_valid / out_ready with kind, payload_byte, frame_type and
// last_of_frame, one result per request. Header bytes give no result; the 14th
// header byte gives an error or empty-frame result, or nothing when a payload
// follows. Every payload byte gives one result.
// Config: max_payload is written by cfg_wr_en / cfg_wr_data; write it only
// while the block is idle. A length is checked against it on the 14th byte.
// Each result is registered into the result register, or into the skid register
// when that is full. Throughput: one byte per cycle while in_ready is high; the
// frame state registers update in a single pass per byte, and a two-entry output
// buffer (result register plus skid register) decouples the sides.
// Receiver stall: the result register holds; one more result lands in the skid
// register, then in_ready drops until the receiver takes a result.
// Reset: rst_n clears the buffer, returns to the header phase, clears any
// sticky error and loads max_payload with 8 MiB.
module ipc_frame_deframer
    import ifd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [31:0] frame_type,
    output logic        last_of_frame,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    localparam logic [3:0] LAST_HDR_IDX = 4'(HDR_BYTES - 1);
    localparam logic [3:0] MAGIC_END    = 4'(MAGIC_BYTES);
    localparam logic [3:0] LEN_END      = 4'(MAGIC_BYTES + 4);

    // Frame state
    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_idx_reg, hdr_idx_next;
    logic        magic_good_reg, magic_good_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] max_payload_reg;

    // Output buffer
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    result_t     skid_reg, skid_next;
    logic        skid_valid_reg, skid_valid_next;

    result_t     res;
    logic        res_valid;
    logic        accept;
    logic        take;
    logic [1:0]  lane;
    logic [31:0] type_acc;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;

    // Byte lane within the length or type word.
    assign lane = 2'(hdr_idx_reg - MAGIC_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            hdr_idx_reg    <= '0;
            magic_good_reg <= 1'b1;
            length_reg     <= '0;
            type_reg       <= '0;
            left_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            magic_good_reg <= magic_good_next;
            length_reg     <= length_next;
            type_reg       <= type_next;
            left_reg       <= left_next;
        end
    end

    // Per-byte frame logic: next state and the result this byte causes.
    always_comb
    begin
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        magic_good_next = magic_good_reg;
        length_next     = length_reg;
        type_acc        = type_reg;
        left_next       = left_reg;
        res_valid       = 1'b0;
        res.kind          = KIND_REJECTED;
        res.payload_byte  = '0;
        res.last_of_frame = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (hdr_idx_reg < MAGIC_END)
                begin
                    if (byte_in != magic_byte(hdr_idx_reg[2:0]))
                    begin
                        magic_good_next = 1'b0;
                    end
                end
                else if (hdr_idx_reg < LEN_END)
                begin
                    length_next[8*lane +: 8] = byte_in;
                end
                else
                begin
                    type_acc[8*lane +: 8] = byte_in;
                end

                if (hdr_idx_reg != LAST_HDR_IDX)
                begin
                    hdr_idx_next = hdr_idx_reg + 4'd1;
                end
                else
                begin
                    hdr_idx_next = '0;
                    if (!magic_good_reg)
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = KIND_BAD_MAGIC;
                    end
                    else if (length_reg > max_payload_reg)
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = KIND_TOO_LONG;
                    end
                    else if (length_reg == '0)
                    begin
                        res_valid         = 1'b1;
                        res.kind          = KIND_EMPTY;
                        res.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                        left_next  = length_reg;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res_valid         = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = byte_in;
                res.last_of_frame = (left_reg <= 32'd1);
                left_next         = left_reg - 32'd1;
            end
            default:
            begin
                // Sticky error: reject every byte until reset.
                res_valid = 1'b1;
                res.kind  = KIND_REJECTED;
            end
        endcase

        res.frame_type = type_acc;
        type_next      = type_acc;

        // Frame done (empty frame or last payload byte): start a new header.
        if (res_valid && res.last_of_frame)
        begin
            phase_next      = PH_HEADER;
            hdr_idx_next    = '0;
            magic_good_next = 1'b1;
            length_next     = '0;
            type_next       = '0;
            left_next       = '0;
        end
    end

    // Output buffer: result register with a skid register behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = accept && res_valid;
            end
        end
        else if (accept && res_valid)
        begin
            if (!out_valid_reg)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign payload_byte  = out_reg.payload_byte;
    assign frame_type    = out_reg.frame_type;
    assign last_of_frame = out_reg.last_of_frame;

endmodule

@@ hdl/ifd_checker.sv @@
module ifd_checker
    import ifd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  payload_byte,
    input logic [31:0] frame_type,
    input logic        last_of_frame
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(frame_type))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= KIND_REJECTED)
        else $error("kind out of range");

    // Non-payload results carry no byte; only payload or empty frames end a frame.
    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
        else $error("payload byte on a non-payload result");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_EMPTY || kind == KIND_BAD_MAGIC ||
                      kind == KIND_TOO_LONG || kind == KIND_REJECTED)
        |-> last_of_frame == (kind == KIND_EMPTY))
        else $error("bad last-of-frame mark");

    // Input only backs up behind a waiting result.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind ipc_frame_deframer ifd_checker u_ifd_checker (.*);

@@ verif/ipc_frame_deframer_check.sv @@
module ipc_frame_deframer_check
    import ifd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  kind,
    input  logic [7:0]  payload_byte,
    input  logic [31:0] frame_type,
    input  logic        last_of_frame,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output int          fail_count,
    output int          pending,
    output int          results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // "i3-ipc", byte 0 in the low lane
    localparam logic [47:0] HDR_MAGIC = 48'h63_70_69_2D_33_69;

    phase_t      phase;
    logic [3:0]  hdr_idx;
    logic        magic_ok;
    logic [31:0] frame_len;
    logic [31:0] type_acc;
    logic [31:0] remaining;
    logic [31:0] max_len;

    result_t     frame_results_q[$];
    result_t     want;

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
    end

    task automatic restart_frame();
        phase     = PH_HEADER;
        hdr_idx   = '0;
        magic_ok  = 1'b1;
        frame_len = '0;
        type_acc  = '0;
        remaining = '0;
    endtask

    // Advance the frame state by one stream byte; queue the result it causes.
    task automatic deframe_byte(input logic [7:0] b);
        result_t r;
        bit      has_result;
        r          = '0;
        has_result = 1'b0;
        case (phase)
            PH_HEADER:
            begin
                if (hdr_idx < MAGIC_BYTES)
                begin
                    if (b != HDR_MAGIC[8*hdr_idx +: 8])
                        magic_ok = 1'b0;
                end
                else if (hdr_idx < MAGIC_BYTES + 4)
                    frame_len |= 32'(b) << (8 * (hdr_idx - MAGIC_BYTES));
                else
                    type_acc |= 32'(b) << (8 * (hdr_idx - MAGIC_BYTES - 4));

                if (hdr_idx + 1 < HDR_BYTES)
                    hdr_idx = hdr_idx + 4'd1;
                else
                begin
                    hdr_idx      = '0;
                    r.frame_type = type_acc;
                    has_result   = 1'b1;
                    if (!magic_ok)
                    begin
                        phase  = PH_ERROR;
                        r.kind = KIND_BAD_MAGIC;
                    end
                    else if (frame_len > max_len)
                    begin
                        phase  = PH_ERROR;
                        r.kind = KIND_TOO_LONG;
                    end
                    else if (frame_len == 0)
                    begin
                        r.kind          = KIND_EMPTY;
                        r.last_of_frame = 1'b1;
                        restart_frame();
                    end
                    else
                    begin
                        has_result = 1'b0;
                        phase      = PH_PAYLOAD;
                        remaining  = frame_len;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                r.kind          = KIND_PAYLOAD;
                r.payload_byte  = b;
                r.frame_type    = type_acc;
                r.last_of_frame = (remaining <= 1);
                has_result      = 1'b1;
                if (r.last_of_frame)
                    restart_frame();
                else
                    remaining = remaining - 1;
            end
            default:
            begin
                // sticky error: flag every later byte
                r.kind       = KIND_REJECTED;
                r.frame_type = type_acc;
                has_result   = 1'b1;
            end
        endcase
        if (has_result)
            frame_results_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_frame();
            max_len = MAX_PAYLOAD_RESET;
            frame_results_q.delete();
            pending = 0;
        end
        else
        begin
            // A byte taken at the same edge as a limit write sees the old limit.
            if (in_valid && in_ready)
                deframe_byte(byte_in);
            if (cfg_wr_en)
                max_len = cfg_wr_data;
            if (out_valid && out_ready)
            begin
                if (frame_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %h byte %h",
                             $time, kind, payload_byte);
                    fail_count++;
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
                    check_field("frame_type", want.frame_type, frame_type);
                    check_field("last_of_frame", 32'(want.last_of_frame),
                                32'(last_of_frame));
                    results_checked++;
                end
            end
            pending = frame_results_q.size();
        end
    end

endmodule

@@ verif/ipc_frame_deframer_tb.sv @@
module ipc_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ifd_pkg::*;

    // Run shape: stop random frames near this many bytes, then close the
    // stream with one bad header and a tail of rejected bytes.
    localparam int RANDOM_TARGET = 1270;
    localparam int PHASE_BYTES   = 180;
    localparam int TAIL_BYTES    = 30;
    // Settling wait before touching max_payload.
    localparam int IDLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT   = 400000;

    // How the run closes its stream; only one sticky error fits in a run.
    typedef enum int
    {
        END_BAD_MAGIC,
        END_TOO_LONG,
        END_BOTH
    } close_err_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_in;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [31:0] frame_type;
    logic        last_of_frame;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    int          fail_count;
    int          pending;
    int          results_checked;

    // Stimulus bookkeeping
    int          bytes_sent;
    int          frames_sent;
    int          cfg_writes;
    int          cycle_count;
    int unsigned stall_left;
    bit          no_gaps;
    logic [31:0] max_now;

    ipc_frame_deframer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_in       (byte_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .frame_type    (frame_type),
        .last_of_frame (last_of_frame),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    ipc_frame_deframer_check u_frame_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .byte_in         (byte_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .payload_byte    (payload_byte),
        .frame_type      (frame_type),
        .last_of_frame   (last_of_frame),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    // Draw the wait before one request; burst stretches draw none.
    function automatic int unsigned draw_wait();
        if (no_gaps)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Pick a payload length that fits under the limit: mostly short, some empty,
    // some exactly at the limit, a few longer ones.
    function automatic int unsigned pick_length(input logic [31:0] limit);
        int unsigned cap;
        int unsigned r;
        cap = (limit > 32'd120) ? 120 : limit;
        r   = $urandom_range(0, 9);
        if (cap == 0 || r == 0)
            return 0;
        if (r == 1 && limit <= 32'd120)
            return cap;
        if (r < 8)
            return $urandom_range(1, (cap < 16) ? cap : 16);
        return $urandom_range(1, cap);
    endfunction

    function automatic logic [31:0] pick_type();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: hold off a drawn number of cycles per result, plus any long
    // stall that the stimulus asks for, then take the next result.
    always
    begin : receiver
        int unsigned gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap != 0 || stall_left != 0)
        begin
            out_ready = 1'b0;
            repeat (gap) @(negedge clk);
            while (stall_left != 0)
            begin
                stall_left--;
                @(negedge clk);
            end
        end
        out_ready = 1'b1;
        do @(posedge clk); while (!out_valid);
    end

    // Offer one byte; hold valid and data until the request is taken.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        byte_in  = b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Send header bytes hdr_first..hdr_last; corrupt the magic at bad_pos
    // (no corruption when bad_pos is negative).
    task automatic send_header_part(input logic [31:0] len, input logic [31:0] typ,
                                    input int hdr_first, input int hdr_last,
                                    input int bad_pos);
        logic [7:0] b;
        for (int i = hdr_first; i <= hdr_last; i++)
        begin
            if (i < MAGIC_BYTES)
                b = magic_byte(3'(i));
            else if (i < MAGIC_BYTES + 4)
                b = len[8*(i - MAGIC_BYTES) +: 8];
            else
                b = typ[8*(i - MAGIC_BYTES - 4) +: 8];
            if (i == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            send_byte(b);
        end
    endtask

    task automatic send_frame(input int unsigned len, input logic [31:0] typ);
        send_header_part(len, typ, 0, HDR_BYTES - 1, -1);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        frames_sent++;
    endtask

    // Drain: drop valid, wait for every expected result, let the block settle,
    // then write the limit.
    task automatic write_max_payload(input logic [31:0] val);
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (IDLE_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        max_now   = val;
        cfg_writes++;
    endtask

    // Watchdog: end the run if it hangs.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int          phase_no;
        int          phase_end;
        logic [31:0] setting;
        logic [31:0] max_final;
        logic [31:0] len;
        logic [31:0] typ;
        int          bad_pos;
        close_err_t  close_sel;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        byte_in     = '0;
        out_ready   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        stall_left  = 0;
        no_gaps     = 1'b0;
        bytes_sent  = 0;
        frames_sent = 0;
        cfg_writes  = 0;
        max_now     = MAX_PAYLOAD_RESET;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: under the reset limit, an empty frame with an all-ones type,
        // then a two-byte frame with a zero type carrying both byte extremes.
        send_header_part(32'd0, 32'hFFFF_FFFF, 0, HDR_BYTES - 1, -1);
        frames_sent++;
        send_header_part(32'd2, 32'h0000_0000, 0, HDR_BYTES - 1, -1);
        send_byte(8'h00);
        send_byte(8'hFF);
        frames_sent++;

        // Random well-formed frames under a rotation of limits, extremes first.
        phase_no = 0;
        while (bytes_sent < RANDOM_TARGET)
        begin
            case (phase_no % 6)
                0:       setting = 32'd0;
                1:       setting = 32'd1;
                2:       setting = 32'd17;
                3:       setting = 32'hFFFF_FFFF;
                4:       setting = 32'd300;
                default: setting = $urandom_range(2, 64);
            endcase
            write_max_payload(setting);
            no_gaps   = (phase_no % 3 == 1);
            phase_end = bytes_sent + PHASE_BYTES;
            if (phase_end > RANDOM_TARGET)
                phase_end = RANDOM_TARGET;
            if (phase_no == 3)
            begin
                // Stall the receiver long while a long frame streams in, so the
                // output buffer fills and input requests back up.
                stall_left = 120;
                send_frame(48, pick_type());
            end
            while (bytes_sent < phase_end)
                send_frame(pick_length(max_now), pick_type());
            phase_no++;
        end

        // Close the stream with one bad header. The limit is rewritten
        // mid-header, so the length is judged against the new value.
        no_gaps   = 1'b0;
        max_final = $urandom_range(0, 40);
        close_sel = close_err_t'($urandom_range(0, 2));
        typ       = pick_type();
        bad_pos   = $urandom_range(0, MAGIC_BYTES - 1);
        case ($urandom_range(0, 2))
            0:       len = max_final + 1;
            1:       len = 32'hFFFF_FFFF;
            default: len = $urandom | 32'h0100_0000;
        endcase
        if (close_sel == END_BAD_MAGIC)
            len = $urandom_range(0, max_final);
        else if (close_sel == END_TOO_LONG)
            bad_pos = -1;

        send_header_part(len, typ, 0, MAGIC_BYTES + 3, bad_pos);
        write_max_payload(max_final);
        send_header_part(len, typ, MAGIC_BYTES + 4, HDR_BYTES - 1, bad_pos);
        frames_sent++;
        // Every byte after the error must come back rejected.
        repeat (TAIL_BYTES) send_byte(8'($urandom_range(0, 255)));

        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (4 * IDLE_CYCLES) @(negedge clk);

        $display("Covered %0d stream bytes in %0d frames over %0d max_payload writes; %0d results compared.",
                 bytes_sent, frames_sent, cfg_writes, results_checked);
        $display("Stream closed by a %s header followed by %0d rejected bytes.",
                 close_sel.name(), TAIL_BYTES);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
